// File: hdl/sfs_pkg.sv
// Shared types, constants and the CRC-16 byte update for the serial frame splitter.
// Used by sfs_parser, sfs_queue and serial_frame_splitter_modbus_crc_unit.
package sfs_pkg;

  localparam int unsigned SfsMaxSensorFrame = 1024;
  localparam int unsigned SfsQueueDepth     = 4;

  localparam logic [1:0] RegSlaveAddress     = 2'd0;
  localparam logic [1:0] RegSensorMarkFirst  = 2'd1;
  localparam logic [1:0] RegSensorMarkSecond = 2'd2;
  localparam logic [1:0] RegSensorLimit      = 2'd3;

  localparam logic [7:0]  ResetSlaveAddress = 8'h01;
  localparam logic [10:0] ResetSensorLimit  = 11'd1024;

  localparam logic [1:0] StatusGood     = 2'd0;
  localparam logic [1:0] StatusCrcError = 2'd1;
  localparam logic [1:0] StatusBadFunc  = 2'd2;
  localparam logic [1:0] StatusOverlong = 2'd3;

  localparam logic KindModbus = 1'b0;
  localparam logic KindSensor = 1'b1;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [7:0] FuncExceptionBit = 8'h80;
  localparam logic [7:0] FuncWriteSingle  = 8'h06;
  localparam logic [7:0] FuncWriteMulti   = 8'h10;
  localparam logic [7:0] FuncWriteCoils   = 8'h0F;
  localparam logic [7:0] FuncReadFirst    = 8'h01;
  localparam logic [7:0] FuncReadLast     = 8'h04;
  localparam logic [8:0] LenException     = 9'd5;
  localparam logic [8:0] LenWriteEcho     = 9'd8;
  localparam logic [8:0] LenReadOverhead  = 9'd5;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [7:0]  mark_first;
    logic [7:0]  mark_second;
    logic [10:0] length_limit;
    logic [15:0] crc_seed;
  } sfs_cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       kind;
    logic       done;
    logic [1:0] status;
  } sfs_result_t;

  typedef struct packed {
    logic        first_vld;
    logic        second_vld;
    sfs_result_t first;
    sfs_result_t second;
  } sfs_push_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

  function automatic sfs_result_t mk_result(input logic [7:0] data, input logic kind,
                                            input logic done, input logic [1:0] status);
    sfs_result_t r;
    r.data   = data;
    r.kind   = kind;
    r.done   = done;
    r.status = status;
    return r;
  endfunction

endpackage

// File: hdl/sfs_parser.sv
// Front end: takes one received byte per beat, tracks frame state and CRC,
// and produces up to two result records. Depends on sfs_pkg.
module sfs_parser #(
  parameter int unsigned MAX_SENSOR_FRAME = sfs_pkg::SfsMaxSensorFrame
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  logic [7:0]         rx_byte_i,
  input  sfs_pkg::sfs_cfg_t  cfg_i,
  output sfs_pkg::sfs_push_t push_o
);
  import sfs_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_SENSOR_FRAME + 1);
  localparam int unsigned CntW = (CW > 9) ? CW : 9;
  localparam int unsigned LimW = (CntW > 11) ? CntW : 11;
  localparam int unsigned PosW = CntW + 1;

  localparam logic [2:0] ModeHunt    = 3'd0;
  localparam logic [2:0] ModeSensor  = 3'd1;
  localparam logic [2:0] ModeMbFunc  = 3'd2;
  localparam logic [2:0] ModeMbCount = 3'd3;
  localparam logic [2:0] ModeMbBody  = 3'd4;

  logic [2:0]      mode_q, mode_d;
  logic            pending_q, pending_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [8:0]      exp_q, exp_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      prev_q, prev_d;
  logic            lowm_q, lowm_d;

  logic [7:0]      b;
  logic [15:0]     crc_upd;
  logic            func_exc, func_write, func_read, func_known;
  logic [2:0]      func_mode;
  logic [8:0]      func_len;
  logic [CntW-1:0] cnt_inc;
  logic [LimW-1:0] lim_raw, lim_c;
  logic            sensor_footer, sensor_over;
  logic [PosW-1:0] pos_ext, exp_ext;
  logic            crc_good;

  assign b       = rx_byte_i;
  assign crc_upd = crc_byte((mode_q == ModeHunt) ? cfg_i.crc_seed : crc_q, b);

  assign func_exc   = (b & FuncExceptionBit) != 8'h00;
  assign func_write = (b == FuncWriteSingle) || (b == FuncWriteMulti) || (b == FuncWriteCoils);
  assign func_read  = (b >= FuncReadFirst) && (b <= FuncReadLast);
  assign func_known = func_exc || func_write || func_read;
  assign func_mode  = func_read ? ModeMbCount : ModeMbBody;
  assign func_len   = func_exc ? LenException : (func_write ? LenWriteEcho : 9'd0);

  assign cnt_inc = cnt_q + CntW'(1);
  assign lim_raw = LimW'(cfg_i.length_limit);
  always_comb begin
    if (lim_raw < LimW'(4)) begin
      lim_c = LimW'(4);
    end else if (lim_raw > LimW'(MAX_SENSOR_FRAME)) begin
      lim_c = LimW'(MAX_SENSOR_FRAME);
    end else begin
      lim_c = lim_raw;
    end
  end
  assign sensor_footer = (cnt_inc >= CntW'(4)) && (prev_q == cfg_i.mark_second) &&
                         (b == cfg_i.mark_first);
  assign sensor_over   = LimW'(cnt_inc) >= lim_c;

  assign pos_ext  = PosW'(cnt_inc);
  assign exp_ext  = PosW'(exp_q);
  assign crc_good = lowm_q && (b == crc_q[15:8]);

  always_comb begin
    mode_d    = mode_q;
    pending_d = pending_q;
    cnt_d     = cnt_q;
    exp_d     = exp_q;
    crc_d     = crc_q;
    prev_d    = prev_q;
    lowm_d    = lowm_q;
    push_o    = '0;
    if (take_i) begin
      case (mode_q)
        ModeHunt: begin
          pending_d = 1'b0;
          if (pending_q && (b == cfg_i.mark_second)) begin
            push_o.first_vld  = 1'b1;
            push_o.first      = mk_result(cfg_i.mark_first, KindSensor, 1'b0, StatusGood);
            push_o.second_vld = 1'b1;
            push_o.second     = mk_result(b, KindSensor, 1'b0, StatusGood);
            cnt_d  = CntW'(2);
            prev_d = b;
            mode_d = ModeSensor;
          end else if (pending_q && (cfg_i.mark_first == cfg_i.slave_address)) begin
            push_o.first_vld  = 1'b1;
            push_o.first      = mk_result(cfg_i.mark_first, KindModbus, 1'b0, StatusGood);
            push_o.second_vld = 1'b1;
            crc_d  = crc_upd;
            lowm_d = 1'b0;
            if (func_known) begin
              push_o.second = mk_result(b, KindModbus, 1'b0, StatusGood);
              cnt_d  = CntW'(2);
              exp_d  = func_len;
              mode_d = func_mode;
            end else begin
              push_o.second = mk_result(b, KindModbus, 1'b1, StatusBadFunc);
              cnt_d  = '0;
              exp_d  = '0;
              mode_d = ModeHunt;
            end
          end else if (b == cfg_i.mark_first) begin
            pending_d = 1'b1;
          end else if (b == cfg_i.slave_address) begin
            push_o.first_vld = 1'b1;
            push_o.first     = mk_result(b, KindModbus, 1'b0, StatusGood);
            crc_d  = cfg_i.crc_seed;
            cnt_d  = CntW'(1);
            exp_d  = '0;
            lowm_d = 1'b0;
            mode_d = ModeMbFunc;
          end
        end
        ModeSensor: begin
          push_o.first_vld = 1'b1;
          if (sensor_footer) begin
            push_o.first = mk_result(b, KindSensor, 1'b1, StatusGood);
            mode_d    = ModeHunt;
            pending_d = 1'b0;
            cnt_d     = '0;
          end else if (sensor_over) begin
            push_o.first = mk_result(b, KindSensor, 1'b1, StatusOverlong);
            mode_d    = ModeHunt;
            pending_d = 1'b0;
            cnt_d     = '0;
          end else begin
            push_o.first = mk_result(b, KindSensor, 1'b0, StatusGood);
            prev_d = b;
            cnt_d  = cnt_inc;
          end
        end
        ModeMbFunc: begin
          push_o.first_vld = 1'b1;
          crc_d = crc_upd;
          if (func_known) begin
            push_o.first = mk_result(b, KindModbus, 1'b0, StatusGood);
            cnt_d  = CntW'(2);
            exp_d  = func_len;
            mode_d = func_mode;
          end else begin
            push_o.first = mk_result(b, KindModbus, 1'b1, StatusBadFunc);
            cnt_d     = '0;
            pending_d = 1'b0;
            mode_d    = ModeHunt;
          end
        end
        ModeMbCount: begin
          push_o.first_vld = 1'b1;
          push_o.first     = mk_result(b, KindModbus, 1'b0, StatusGood);
          crc_d  = crc_upd;
          exp_d  = LenReadOverhead + {1'b0, b};
          cnt_d  = CntW'(3);
          mode_d = ModeMbBody;
        end
        ModeMbBody: begin
          push_o.first_vld = 1'b1;
          cnt_d = cnt_inc;
          if ((pos_ext + PosW'(2)) <= exp_ext) begin
            push_o.first = mk_result(b, KindModbus, 1'b0, StatusGood);
            crc_d = crc_upd;
          end else if ((pos_ext + PosW'(1)) == exp_ext) begin
            push_o.first = mk_result(b, KindModbus, 1'b0, StatusGood);
            lowm_d = (b == crc_q[7:0]);
          end else begin
            push_o.first = mk_result(b, KindModbus, 1'b1,
                                     crc_good ? StatusGood : StatusCrcError);
            cnt_d     = '0;
            pending_d = 1'b0;
            mode_d    = ModeHunt;
          end
        end
        default: begin
          mode_d    = ModeHunt;
          pending_d = 1'b0;
          cnt_d     = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeHunt;
      pending_q <= 1'b0;
      cnt_q     <= '0;
      exp_q     <= '0;
      crc_q     <= CrcInit;
      prev_q    <= '0;
      lowm_q    <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      pending_q <= pending_d;
      cnt_q     <= cnt_d;
      exp_q     <= exp_d;
      crc_q     <= crc_d;
      prev_q    <= prev_d;
      lowm_q    <= lowm_d;
    end
  end

endmodule

// File: hdl/sfs_queue.sv
// Back end: result queue taking up to two records per cycle and handing
// one per beat to the output channel. Depends on sfs_pkg.
module sfs_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfs_pkg::sfs_push_t   push_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output sfs_pkg::sfs_result_t head_o,
  output logic [$clog2(sfs_pkg::SfsQueueDepth+1)-1:0] level_o
);
  import sfs_pkg::*;

  localparam int unsigned PtrW = $clog2(SfsQueueDepth);
  localparam int unsigned LvlW = $clog2(SfsQueueDepth + 1);

  sfs_result_t     mem [SfsQueueDepth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [LvlW-1:0] cnt_q, cnt_d;
  logic [LvlW-1:0] n_push;
  logic            pop;
  logic [PtrW-1:0] wptr_next;

  assign pop       = out_valid_o && !out_stall_i;
  assign n_push    = LvlW'(push_i.first_vld) + LvlW'(push_i.second_vld);
  assign wptr_next = wptr_q + PtrW'(1);
  assign wptr_d    = wptr_q + PtrW'(n_push);
  assign rptr_d    = pop ? rptr_q + PtrW'(1) : rptr_q;
  assign cnt_d     = cnt_q + n_push - LvlW'(pop);

  assign out_valid_o = cnt_q != '0;
  assign head_o      = mem[rptr_q];
  assign level_o     = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i.first_vld) begin
      mem[wptr_q] <= push_i.first;
    end
    if (push_i.second_vld) begin
      mem[wptr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// File: hdl/serial_frame_splitter_modbus_crc_unit.sv
// Channel   Dir  Handshake                 Payload
// rx        in   rx_valid_i / rx_stall_o   rx_byte_i
// out       out  out_valid_o / out_stall_i out_byte_o, byte_present_o, frame_kind_o,
//                                          frame_done_o, frame_status_o
// apb       in   psel, penable, pready     paddr, pwrite, pwdata, prdata
//
// Unless stalled, one byte is taken per cycle; its results are queued the next cycle.
// A byte yields up to two results; the output drains one result per cycle unless stalled.
// rx_stall_o rises while the result queue has fewer than two free entries.
// Reset returns the parser to hunting and the registers to their reset values.
// Top level: configuration registers, sfs_parser (front), sfs_queue (back). Uses sfs_pkg.
module serial_frame_splitter_modbus_crc_unit #(
  parameter int unsigned MAX_SENSOR_FRAME = sfs_pkg::SfsMaxSensorFrame
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_present_o,
  output logic        frame_kind_o,
  output logic        frame_done_o,
  output logic [1:0]  frame_status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sfs_pkg::*;

  localparam int unsigned LvlW = $clog2(SfsQueueDepth + 1);

  sfs_cfg_t        cfg_q;
  sfs_push_t       push;
  sfs_result_t     head;
  logic [LvlW-1:0] level;
  logic            take;
  logic            cfg_wr;
  logic [1:0]      reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave_address <= ResetSlaveAddress;
      cfg_q.mark_first    <= '0;
      cfg_q.mark_second   <= '0;
      cfg_q.length_limit  <= ResetSensorLimit;
      cfg_q.crc_seed      <= crc_byte(CrcInit, ResetSlaveAddress);
    end else if (cfg_wr) begin
      case (reg_idx)
        RegSlaveAddress: begin
          cfg_q.slave_address <= pwdata[7:0];
          cfg_q.crc_seed      <= crc_byte(CrcInit, pwdata[7:0]);
        end
        RegSensorMarkFirst:  cfg_q.mark_first   <= pwdata[7:0];
        RegSensorMarkSecond: cfg_q.mark_second  <= pwdata[7:0];
        RegSensorLimit:      cfg_q.length_limit <= pwdata[10:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegSlaveAddress:     prdata = {24'h0, cfg_q.slave_address};
      RegSensorMarkFirst:  prdata = {24'h0, cfg_q.mark_first};
      RegSensorMarkSecond: prdata = {24'h0, cfg_q.mark_second};
      RegSensorLimit:      prdata = {21'h0, cfg_q.length_limit};
      default:             prdata = '0;
    endcase
  end

  assign rx_stall_o = level > LvlW'(SfsQueueDepth - 2);
  assign take       = rx_valid_i && !rx_stall_o;

  sfs_parser #(
    .MAX_SENSOR_FRAME(MAX_SENSOR_FRAME)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .rx_byte_i(rx_byte_i),
    .cfg_i    (cfg_q),
    .push_o   (push)
  );

  sfs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .head_o     (head),
    .level_o    (level)
  );

  assign out_byte_o     = head.data;
  assign byte_present_o = 1'b1;
  assign frame_kind_o   = head.kind;
  assign frame_done_o   = head.done;
  assign frame_status_o = head.status;

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= LvlW'(SfsQueueDepth))
    else $error("result queue overflow");

  a_no_push_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |-> !push.first_vld && !push.second_vld)
    else $error("result pushed without an accepted byte");

  a_status_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_status_o != StatusGood) |-> frame_done_o)
    else $error("error status on a byte that does not end a frame");

  a_sensor_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_kind_o == KindSensor) |->
      (frame_status_o == StatusGood) || (frame_status_o == StatusOverlong))
    else $error("Modbus status on a sensor frame byte");
`endif

endmodule

// File: dv/tb_serial_frame_splitter_modbus_crc_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for serial_frame_splitter_modbus_crc_unit: a directed table, then
// random sensor and Modbus RTU byte streams, beats matched to the table or a local parser.
// Depends on sfs_pkg and the unit itself; programs the splitter over its APB port.
module tb_serial_frame_splitter_modbus_crc_unit;
  import sfs_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       kind;
    logic       done;
    logic [1:0] status;
  } split_beat_t;

  typedef enum logic [2:0] {
    StepByte, StepCrcLow, StepCrcHigh, StepCrcLowBad, StepConfig
  } step_op_e;

  typedef struct packed {
    step_op_e    op;
    logic [7:0]  rx;
    logic        typed;
    logic [1:0]  n_beats;
    split_beat_t b0;
    split_beat_t b1;
    logic [1:0]  regsel;
    logic [10:0] value;
  } script_row_t;

  typedef enum logic [2:0] {
    ParseHunt, ParseSensor, ParseFunc, ParseCount, ParseBody
  } parse_state_e;

  localparam int          ScriptLen  = 31;
  localparam int          PhaseBeats = 25;
  localparam split_beat_t NoBeat     = '0;
  localparam script_row_t PlainRow   = '0;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        rx_valid_i;
  logic        rx_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  out_byte_o;
  logic        byte_present_o;
  logic        frame_kind_o;
  logic        frame_done_o;
  logic [1:0]  frame_status_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [7:0]  cfg_slave;
  logic [7:0]  cfg_mark1;
  logic [7:0]  cfg_mark2;
  logic [10:0] cfg_limit;

  parse_state_e parse_st;
  logic         mark_held;
  logic [10:0]  frame_cnt;
  logic [8:0]   target_len;
  logic [15:0]  crc_acc;
  logic [7:0]   last_byte;
  logic         crc_lo_ok;

  split_beat_t step_out[$];
  split_beat_t awaited_frame_beats[$];
  script_row_t script[ScriptLen];

  int   mismatches = 0;
  int   rx_beats   = 0;
  logic calm       = 1'b0;
  logic choke_req  = 1'b0;

  serial_frame_splitter_modbus_crc_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_valid_i     (rx_valid_i),
    .rx_stall_o     (rx_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .byte_present_o (byte_present_o),
    .frame_kind_o   (frame_kind_o),
    .frame_done_o   (frame_done_o),
    .frame_status_o (frame_status_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    repeat (8) begin
      if (r[0]) begin
        r = (r >> 1) ^ CrcPoly;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic split_beat_t frame_beat(input logic [7:0] d, input logic k,
                                             input logic dn, input logic [1:0] st);
    return {d, 1'b1, k, dn, st};
  endfunction

  function automatic int sensor_limit_eff();
    int lim;
    lim = int'(cfg_limit);
    if (lim < 4) begin
      return 4;
    end
    if (lim > int'(SfsMaxSensorFrame)) begin
      return int'(SfsMaxSensorFrame);
    end
    return lim;
  endfunction

  function automatic script_row_t rx_row(input step_op_e op, input logic [7:0] v);
    script_row_t r;
    r = '0;
    r.op = op;
    r.rx = v;
    return r;
  endfunction

  function automatic script_row_t typed_row(input logic [7:0] v, input logic [1:0] n,
                                            input split_beat_t b0, input split_beat_t b1);
    script_row_t r;
    r = '0;
    r.op = StepByte;
    r.rx = v;
    r.typed = 1'b1;
    r.n_beats = n;
    r.b0 = b0;
    r.b1 = b1;
    return r;
  endfunction

  function automatic script_row_t cfg_row(input logic [1:0] idx, input logic [10:0] v);
    script_row_t r;
    r = '0;
    r.op = StepConfig;
    r.regsel = idx;
    r.value = v;
    return r;
  endfunction

  task automatic close_frame();
    parse_st = ParseHunt;
    mark_held = 1'b0;
    frame_cnt = '0;
  endtask

  task automatic open_modbus(input logic [7:0] b);
    crc_acc = crc16_next(CrcInit, b);
    frame_cnt = 11'd1;
    target_len = '0;
    crc_lo_ok = 1'b0;
    parse_st = ParseFunc;
    step_out.push_back(frame_beat(b, KindModbus, 1'b0, StatusGood));
  endtask

  task automatic take_function(input logic [7:0] b);
    crc_acc = crc16_next(crc_acc, b);
    frame_cnt = 11'd2;
    if ((b & FuncExceptionBit) != 0) begin
      target_len = LenException;
      parse_st = ParseBody;
    end else if (b == FuncWriteSingle || b == FuncWriteMulti || b == FuncWriteCoils) begin
      target_len = LenWriteEcho;
      parse_st = ParseBody;
    end else if (b >= FuncReadFirst && b <= FuncReadLast) begin
      parse_st = ParseCount;
    end else begin
      step_out.push_back(frame_beat(b, KindModbus, 1'b1, StatusBadFunc));
      close_frame();
      return;
    end
    step_out.push_back(frame_beat(b, KindModbus, 1'b0, StatusGood));
  endtask

  task automatic hunt_on(input logic [7:0] b);
    if (b == cfg_mark1) begin
      mark_held = 1'b1;
    end else if (b == cfg_slave) begin
      open_modbus(b);
    end
  endtask

  task automatic advance_parser(input logic [7:0] b);
    int pos;
    case (parse_st)
      ParseHunt: begin
        if (mark_held) begin
          mark_held = 1'b0;
          if (b == cfg_mark2) begin
            step_out.push_back(frame_beat(cfg_mark1, KindSensor, 1'b0, StatusGood));
            step_out.push_back(frame_beat(b, KindSensor, 1'b0, StatusGood));
            frame_cnt = 11'd2;
            last_byte = b;
            parse_st = ParseSensor;
          end else if (cfg_mark1 == cfg_slave) begin
            open_modbus(cfg_mark1);
            take_function(b);
          end else begin
            hunt_on(b);
          end
        end else begin
          hunt_on(b);
        end
      end
      ParseSensor: begin
        frame_cnt = frame_cnt + 11'd1;
        if (frame_cnt >= 11'd4 && last_byte == cfg_mark2 && b == cfg_mark1) begin
          step_out.push_back(frame_beat(b, KindSensor, 1'b1, StatusGood));
          close_frame();
        end else if (int'(frame_cnt) >= sensor_limit_eff()) begin
          step_out.push_back(frame_beat(b, KindSensor, 1'b1, StatusOverlong));
          close_frame();
        end else begin
          step_out.push_back(frame_beat(b, KindSensor, 1'b0, StatusGood));
          last_byte = b;
        end
      end
      ParseFunc: take_function(b);
      ParseCount: begin
        crc_acc = crc16_next(crc_acc, b);
        target_len = LenReadOverhead + {1'b0, b};
        frame_cnt = 11'd3;
        parse_st = ParseBody;
        step_out.push_back(frame_beat(b, KindModbus, 1'b0, StatusGood));
      end
      ParseBody: begin
        frame_cnt = frame_cnt + 11'd1;
        pos = int'(frame_cnt);
        if (pos + 2 <= int'(target_len)) begin
          crc_acc = crc16_next(crc_acc, b);
          step_out.push_back(frame_beat(b, KindModbus, 1'b0, StatusGood));
        end else if (pos + 1 == int'(target_len)) begin
          crc_lo_ok = (b == crc_acc[7:0]);
          step_out.push_back(frame_beat(b, KindModbus, 1'b0, StatusGood));
        end else begin
          step_out.push_back(frame_beat(b, KindModbus, 1'b1,
                             (crc_lo_ok && b == crc_acc[15:8]) ? StatusGood : StatusCrcError));
          close_frame();
        end
      end
      default: close_frame();
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input script_row_t row);
    @(negedge clk_i);
    if (!calm) begin
      while ($urandom_range(99) < 22) begin
        rx_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    rx_valid_i = 1'b1;
    rx_byte_i = b;
    do @(posedge clk_i); while (rx_stall_o);
    rx_beats++;
    step_out.delete();
    advance_parser(b);
    if (row.typed) begin
      if (row.n_beats > 0) awaited_frame_beats.push_back(row.b0);
      if (row.n_beats > 1) awaited_frame_beats.push_back(row.b1);
    end else begin
      foreach (step_out[i]) awaited_frame_beats.push_back(step_out[i]);
    end
  endtask

  task automatic wait_results_drained();
    @(negedge clk_i) rx_valid_i = 1'b0;
    while (awaited_frame_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [10:0] v);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = {21'd0, v};
    @(negedge clk_i) penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegSlaveAddress:     cfg_slave = v[7:0];
      RegSensorMarkFirst:  cfg_mark1 = v[7:0];
      RegSensorMarkSecond: cfg_mark2 = v[7:0];
      default:             cfg_limit = v;
    endcase
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic program_splitter(input logic [7:0] slave, input logic [7:0] m1,
                                  input logic [7:0] m2, input logic [10:0] lim);
    wait_results_drained();
    apb_write(RegSlaveAddress, {3'd0, slave});
    apb_write(RegSensorMarkFirst, {3'd0, m1});
    apb_write(RegSensorMarkSecond, {3'd0, m2});
    apb_write(RegSensorLimit, lim);
  endtask

  task automatic emit_random_sequence();
    logic [7:0]  seq[$];
    logic [7:0]  fn;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [15:0] crc;
    int          pick;
    int          kind_pick;
    int          len;
    int          lim_eff;
    pick = $urandom_range(99);
    lim_eff = sensor_limit_eff();
    if (pick < 30) begin
      seq.push_back(cfg_mark1);
      seq.push_back(cfg_mark2);
      if (lim_eff <= 64 && $urandom_range(9) == 0) begin
        len = $urandom_range(lim_eff - 4, lim_eff);
      end else begin
        len = $urandom_range(0, (lim_eff < 12) ? lim_eff : 12);
      end
      repeat (len) seq.push_back(8'($urandom_range(255)));
      seq.push_back(cfg_mark2);
      seq.push_back(cfg_mark1);
    end else if (pick < 72) begin
      seq.push_back(cfg_slave);
      kind_pick = $urandom_range(7);
      if (kind_pick < 4) begin
        fn = FuncReadFirst + 8'(kind_pick);
        len = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(6);
        seq.push_back(fn);
        seq.push_back(len[7:0]);
      end else if (kind_pick == 7) begin
        fn = FuncExceptionBit | 8'($urandom_range(127));
        seq.push_back(fn);
        len = 1;
      end else begin
        fn = (kind_pick == 4) ? FuncWriteSingle : (kind_pick == 5) ? FuncWriteCoils
                                                                   : FuncWriteMulti;
        seq.push_back(fn);
        len = 4;
      end
      repeat (len) seq.push_back(8'($urandom_range(255)));
      crc = CrcInit;
      foreach (seq[i]) crc = crc16_next(crc, seq[i]);
      lo = crc[7:0];
      hi = crc[15:8];
      if ($urandom_range(6) == 0) begin
        if ($urandom_range(1) == 1) begin
          lo = lo ^ 8'($urandom_range(1, 255));
        end else begin
          hi = hi ^ 8'($urandom_range(1, 255));
        end
      end
      seq.push_back(lo);
      seq.push_back(hi);
    end else if (pick < 82) begin
      seq.push_back(cfg_slave);
      do fn = 8'($urandom_range(127));
      while ((fn >= FuncReadFirst && fn <= FuncReadLast) || fn == FuncWriteSingle ||
             fn == FuncWriteCoils || fn == FuncWriteMulti);
      seq.push_back(fn);
    end else begin
      repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom_range(255)));
    end
    foreach (seq[i]) send_byte(seq[i], PlainRow);
  endtask

  always @(posedge clk_i) begin : beat_checker
    split_beat_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (awaited_frame_beats.size() == 0) begin
        $error("unexpected beat: out_byte %02h with nothing awaited", out_byte_o);
        mismatches++;
      end else begin
        want = awaited_frame_beats.pop_front();
        if (out_byte_o !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, out_byte_o);
          mismatches++;
        end
        if (byte_present_o !== want.present) begin
          $error("byte_present: expected %0d, got %0d", want.present, byte_present_o);
          mismatches++;
        end
        if (frame_kind_o !== want.kind) begin
          $error("frame_kind: expected %0d, got %0d", want.kind, frame_kind_o);
          mismatches++;
        end
        if (frame_done_o !== want.done) begin
          $error("frame_done: expected %0d, got %0d", want.done, frame_done_o);
          mismatches++;
        end
        if (frame_status_o !== want.status) begin
          $error("frame_status: expected %0d, got %0d", want.status, frame_status_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (choke_req) begin
        repeat (300) begin
          out_stall_i = 1'b1;
          @(negedge clk_i);
        end
        choke_req = 1'b0;
      end
      out_stall_i = (!calm && $urandom_range(99) < 22);
    end
  end

  initial begin
    #4_000_000;
    $display("tb_serial_frame_splitter_modbus_crc_unit: done, errors");
    $finish;
  end

  initial begin
    int         ph;
    int         phase_start;
    int         seq_cnt;
    logic [7:0] s;
    rst_ni = 1'b0;
    rx_valid_i = 1'b0;
    rx_byte_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_slave = ResetSlaveAddress;
    cfg_mark1 = '0;
    cfg_mark2 = '0;
    cfg_limit = ResetSensorLimit;
    parse_st = ParseHunt;
    mark_held = 1'b0;
    frame_cnt = '0;
    target_len = '0;
    crc_acc = CrcInit;
    last_byte = '0;
    crc_lo_ok = 1'b0;

    script[0]  = typed_row(8'hFF, 2'd0, NoBeat, NoBeat);
    script[1]  = typed_row(8'h01, 2'd1, frame_beat(8'h01, KindModbus, 1'b0, StatusGood), NoBeat);
    script[2]  = typed_row(8'h07, 2'd1, frame_beat(8'h07, KindModbus, 1'b1, StatusBadFunc),
                           NoBeat);
    script[3]  = typed_row(8'h00, 2'd0, NoBeat, NoBeat);
    script[4]  = typed_row(8'h00, 2'd2, frame_beat(8'h00, KindSensor, 1'b0, StatusGood),
                           frame_beat(8'h00, KindSensor, 1'b0, StatusGood));
    script[5]  = rx_row(StepByte, 8'h55);
    script[6]  = rx_row(StepByte, 8'h00);
    script[7]  = typed_row(8'h00, 2'd1, frame_beat(8'h00, KindSensor, 1'b1, StatusGood), NoBeat);
    script[8]  = typed_row(8'h01, 2'd1, frame_beat(8'h01, KindModbus, 1'b0, StatusGood), NoBeat);
    script[9]  = rx_row(StepByte, 8'h83);
    script[10] = rx_row(StepByte, 8'h02);
    script[11] = rx_row(StepCrcLow, 8'h00);
    script[12] = rx_row(StepCrcHigh, 8'h00);
    script[13] = cfg_row(RegSensorLimit, 11'd0);
    script[14] = cfg_row(RegSensorMarkFirst, 11'h0AA);
    script[15] = cfg_row(RegSensorMarkSecond, 11'h055);
    script[16] = typed_row(8'hAA, 2'd0, NoBeat, NoBeat);
    script[17] = typed_row(8'h55, 2'd2, frame_beat(8'hAA, KindSensor, 1'b0, StatusGood),
                           frame_beat(8'h55, KindSensor, 1'b0, StatusGood));
    script[18] = rx_row(StepByte, 8'h12);
    script[19] = typed_row(8'h34, 2'd1, frame_beat(8'h34, KindSensor, 1'b1, StatusOverlong),
                           NoBeat);
    script[20] = cfg_row(RegSlaveAddress, 11'h0FF);
    script[21] = cfg_row(RegSensorMarkFirst, 11'h0FF);
    script[22] = cfg_row(RegSensorMarkSecond, 11'h000);
    script[23] = typed_row(8'hFF, 2'd0, NoBeat, NoBeat);
    script[24] = typed_row(8'h06, 2'd2, frame_beat(8'hFF, KindModbus, 1'b0, StatusGood),
                           frame_beat(8'h06, KindModbus, 1'b0, StatusGood));
    script[25] = rx_row(StepByte, 8'h00);
    script[26] = rx_row(StepByte, 8'h01);
    script[27] = rx_row(StepByte, 8'h00);
    script[28] = rx_row(StepByte, 8'h03);
    script[29] = rx_row(StepCrcLowBad, 8'h00);
    script[30] = rx_row(StepCrcHigh, 8'h00);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    foreach (script[i]) begin
      case (script[i].op)
        StepConfig: begin
          wait_results_drained();
          apb_write(script[i].regsel, script[i].value);
        end
        StepCrcLow:    send_byte(crc_acc[7:0], script[i]);
        StepCrcHigh:   send_byte(crc_acc[15:8], script[i]);
        StepCrcLowBad: send_byte(~crc_acc[7:0], script[i]);
        default:       send_byte(script[i].rx, script[i]);
      endcase
    end

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: program_splitter(8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255)), 11'($urandom_range(4, 40)));
        1: program_splitter(8'h00, 8'hFF, 8'hFE, 11'd0);
        2: program_splitter(8'hFF, 8'h00, 8'hFF, 11'd2047);
        3: begin
          s = 8'($urandom_range(255));
          program_splitter(s, s, 8'($urandom_range(255)), 11'd1024);
        end
        4: program_splitter(8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255)), 11'($urandom_range(0, 2047)));
        default: begin
          s = 8'($urandom_range(255));
          program_splitter(8'($urandom_range(255)), s, s, 11'd4);
        end
      endcase
      calm = (ph == 2);
      choke_req = (ph == 0 || ph == 3);
      if (ph == 2) begin
        send_byte(cfg_mark1, PlainRow);
        send_byte(cfg_mark2, PlainRow);
        repeat (SfsMaxSensorFrame + 6) send_byte(8'($urandom_range(255)), PlainRow);
      end
      phase_start = rx_beats;
      seq_cnt = 0;
      while (rx_beats - phase_start < PhaseBeats) begin
        emit_random_sequence();
        seq_cnt++;
        if (ph == 4 && seq_cnt % 4 == 0) wait_results_drained();
      end
      calm = 1'b0;
    end

    wait_results_drained();
    if (mismatches == 0 && awaited_frame_beats.size() == 0) begin
      $display("tb_serial_frame_splitter_modbus_crc_unit: done, clean");
    end else begin
      $display("tb_serial_frame_splitter_modbus_crc_unit: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/sfs_pkg.sv
hdl/sfs_parser.sv
hdl/sfs_queue.sv
hdl/serial_frame_splitter_modbus_crc_unit.sv
dv/tb_serial_frame_splitter_modbus_crc_unit.sv
